// ----- hdl/mtg_pkg.sv -----
// Shared types, constants and functions for the MT19937 generator.
// No dependencies; used by every module of the generator.
package mtg_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned NUM_WORDS = 624;
    localparam int unsigned TAP_OFFSET = 397;
    localparam int unsigned IDX_W = 10;
    localparam int unsigned ADDR_W = 3;

    localparam logic [WORD_W-1:0] MATRIX_A = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] INIT_MULT = 32'd1812433253;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WORDS - 1);

    // register index of the seed
    localparam logic REG_SEED = 1'b0;

    typedef logic [WORD_W-1:0] word_t;

    // control group handed from the sequencer to the feed unit
    typedef struct packed {
        logic             load_seed;
        logic             init;
        logic [IDX_W-1:0] index;
    } feed_ctrl_t;

    function automatic word_t temper(input word_t w);
        word_t y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ----- hdl/mersenne_twister_generator_unit.sv -----
// MT19937 generator: 624 word cells in a shift chain, twisted one word per draw.
// A result beat appears in the cycle after its draw beat is accepted.
// Throughput: one word per cycle; draw_stall follows result_stall while a result waits.
// Reset and every seed write start seeding, during which draw_stall is high.
// Reset sets the seed to 5489. Depends on mtg_pkg, mtg_cell and mtg_feed.
module mersenne_twister_generator_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mtg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       draw_valid,
    output logic                       draw_stall,
    input  logic                       draw,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [31:0]                random_value
);

    typedef enum logic [1:0] {ST_SEED, ST_INIT, ST_RUN} state_t;

    state_t                    state_reg;
    logic [mtg_pkg::IDX_W-1:0] cnt_reg;
    mtg_pkg::word_t            seed_reg;
    logic                      out_valid_reg;
    mtg_pkg::word_t            out_word_reg;

    logic                      seed_write;
    logic                      take;
    logic                      shift_en;
    mtg_pkg::feed_ctrl_t       ctrl;
    mtg_pkg::word_t            feed_word;
    mtg_pkg::word_t            cell_q [mtg_pkg::NUM_WORDS];

    assign pready = 1'b1;
    assign seed_write = psel && penable && pwrite && pready && (paddr[2] == mtg_pkg::REG_SEED);
    assign prdata = (paddr[2] == mtg_pkg::REG_SEED) ? seed_reg : '0;

    assign draw_stall = (state_reg != ST_RUN) || (out_valid_reg && result_stall);
    assign take = draw_valid && !draw_stall && draw;
    assign shift_en = (state_reg != ST_RUN) || take;

    assign ctrl.load_seed = (state_reg == ST_SEED);
    assign ctrl.init = (state_reg == ST_INIT);
    assign ctrl.index = cnt_reg;

    mtg_feed u_feed
    (
        .ctrl   (ctrl),
        .seed   (seed_reg),
        .head   (cell_q[0]),
        .second (cell_q[1]),
        .tap    (cell_q[mtg_pkg::TAP_OFFSET]),
        .tail   (cell_q[mtg_pkg::NUM_WORDS-1]),
        .word   (feed_word)
    );

    // words move towards cell 0; new words enter at the tail
    for (genvar i = 0; i < mtg_pkg::NUM_WORDS; i++)
    begin : g_cell
        if (i == mtg_pkg::NUM_WORDS - 1)
        begin : g_tail
            mtg_cell u_cell
            (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (feed_word),
                .q        (cell_q[i])
            );
        end
        else
        begin : g_body
            mtg_cell u_cell
            (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (cell_q[i+1]),
                .q        (cell_q[i])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SEED;
            cnt_reg       <= '0;
            seed_reg      <= mtg_pkg::DEFAULT_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (seed_write)
            begin
                seed_reg  <= pwdata;
                state_reg <= ST_SEED;
            end
            else
            begin
                case (state_reg)
                    ST_SEED:
                    begin
                        cnt_reg   <= mtg_pkg::IDX_W'(1);
                        state_reg <= ST_INIT;
                    end
                    ST_INIT:
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == mtg_pkg::LAST_IDX)
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                    ST_RUN:
                    begin
                        state_reg <= ST_RUN;
                    end
                    default:
                    begin
                        state_reg <= ST_SEED;
                    end
                endcase
            end

            if (take)
            begin
                out_valid_reg <= 1'b1;
                out_word_reg  <= mtg_pkg::temper(feed_word);
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign random_value = out_word_reg;

endmodule

// ----- hdl/mtg_cell.sv -----
// One word of the generator state in the shift chain.
// Depends on mtg_pkg for the word type.
module mtg_cell
(
    input  logic          clk,
    input  logic          shift_en,
    input  mtg_pkg::word_t d,
    output mtg_pkg::word_t q
);

    mtg_pkg::word_t word_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            word_reg <= d;
        end
    end

    assign q = word_reg;

endmodule

// ----- hdl/mtg_feed.sv -----
// Computes the word shifted into the tail of the chain: seed, seeding
// recurrence or twist. Depends on mtg_pkg.
module mtg_feed
(
    input  mtg_pkg::feed_ctrl_t ctrl,
    input  mtg_pkg::word_t      seed,
    input  mtg_pkg::word_t      head,
    input  mtg_pkg::word_t      second,
    input  mtg_pkg::word_t      tap,
    input  mtg_pkg::word_t      tail,
    output mtg_pkg::word_t      word
);

    mtg_pkg::word_t mixed;
    mtg_pkg::word_t product;
    mtg_pkg::word_t init_word;
    mtg_pkg::word_t y;
    mtg_pkg::word_t twist_word;

    // seeding: the previous word sits in the tail cell
    assign mixed = tail ^ (tail >> 30);
    assign product = mtg_pkg::INIT_MULT * mixed;
    assign init_word = product + {{(mtg_pkg::WORD_W - mtg_pkg::IDX_W){1'b0}}, ctrl.index};

    assign y = (head & mtg_pkg::UPPER_MASK) | (second & mtg_pkg::LOWER_MASK);
    assign twist_word = tap ^ (y >> 1) ^ (y[0] ? mtg_pkg::MATRIX_A : '0);

    always_comb
    begin
        if (ctrl.load_seed)
        begin
            word = seed;
        end
        else if (ctrl.init)
        begin
            word = init_word;
        end
        else
        begin
            word = twist_word;
        end
    end

endmodule

// ----- hdl/mtg_checker.sv -----
// Port-level checks for the MT19937 generator, bound to the top level.
// Depends on mtg_pkg and mersenne_twister_generator_unit.
module mtg_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [mtg_pkg::ADDR_W-1:0] paddr,
    input logic                       pready,
    input logic                       draw_valid,
    input logic                       draw_stall,
    input logic                       draw,
    input logic                       result_valid,
    input logic                       result_stall,
    input logic [31:0]                random_value
);

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(random_value))
        else $error("result beat changed while stalled");

    // a seed write starts reseeding, so draws stall next cycle
    a_seed_stall: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == mtg_pkg::REG_SEED) |=> draw_stall)
        else $error("draw taken right after seed write");

    a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
        draw_valid && !draw_stall && draw |=> result_valid)
        else $error("draw beat gave no result");

    a_zero_draw: assert property (@(posedge clk) disable iff (!rst_n)
        draw_valid && !draw_stall && !draw && !result_valid |=> !result_valid)
        else $error("zero draw produced a result");

endmodule

bind mersenne_twister_generator_unit mtg_checker u_mtg_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pready       (pready),
    .draw_valid   (draw_valid),
    .draw_stall   (draw_stall),
    .draw         (draw),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .random_value (random_value)
);
